### hw/rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int PAGE_W             = 8;
  localparam int CFG_W              = 4;
  localparam int FRAME_IDX_W        = 3;
  localparam int FAULT_W            = 32;
  localparam int MAX_FRAMES_DEFAULT = 8;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(3);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_reference;
  } lrupr_req_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_count;
  } lrupr_rsp_t;

  typedef struct packed {
    logic hit;
    logic found_empty;
    logic evicted;
  } lrupr_dec_t;

endpackage

### hw/rtl/lrupr_lookup.sv
// ----------------------------------------------------------------------------
// lrupr_lookup
// Parallel hit search, empty-frame search and LRU victim choice.
// ----------------------------------------------------------------------------
module lrupr_lookup #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic [lrupr_pkg::PAGE_W-1:0]                  page,
  input  logic [MAX_FRAMES-1:0]                         active,
  input  logic [MAX_FRAMES-1:0][lrupr_pkg::PAGE_W-1:0]  page_r,
  input  logic [MAX_FRAMES-1:0]                         valid_r,
  input  logic [MAX_FRAMES-1:0][$clog2(MAX_FRAMES)-1:0] rank_r,
  output lrupr_pkg::lrupr_dec_t                         dec,
  output logic [$clog2(MAX_FRAMES)-1:0]                 slot,
  output logic [lrupr_pkg::PAGE_W-1:0]                  ev_page
);
  import lrupr_pkg::*;

  localparam int FIDX_W = $clog2(MAX_FRAMES);

  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] empty;
  logic [MAX_FRAMES-1:0] victim;
  logic [FIDX_W-1:0]     hit_slot;
  logic [FIDX_W-1:0]     empty_slot;
  logic [FIDX_W-1:0]     victim_slot;

  function automatic logic [FIDX_W-1:0] lowest_index(input logic [MAX_FRAMES-1:0] m);
    logic [FIDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (m[i]) idx = FIDX_W'(i);
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = active[i] && valid_r[i] && (page_r[i] == page);
      empty[i] = active[i] && !valid_r[i];
      victim[i] = active[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (active[j]) begin
          if (j < i && rank_r[j] >= rank_r[i]) victim[i] = 1'b0;
          if (j > i && rank_r[j] > rank_r[i]) victim[i] = 1'b0;
        end
      end
    end
  end

  assign hit_slot    = lowest_index(match);
  assign empty_slot  = lowest_index(empty);
  assign victim_slot = lowest_index(victim);

  always_comb begin
    dec.hit         = |match;
    dec.found_empty = |empty;
    dec.evicted     = !dec.hit && !dec.found_empty;
    if (dec.hit) begin
      slot = hit_slot;
    end else if (dec.found_empty) begin
      slot = empty_slot;
    end else begin
      slot = victim_slot;
    end
    ev_page = dec.evicted ? page_r[slot] : '0;
  end

endmodule

### hw/rtl/lrupr_frames.sv
// ----------------------------------------------------------------------------
// lrupr_frames
// Frame contents, recency ranks and saturating fault counter.
// ----------------------------------------------------------------------------
module lrupr_frames #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          apply,
  input  logic                                          last,
  input  logic [lrupr_pkg::PAGE_W-1:0]                  page,
  input  logic [$clog2(MAX_FRAMES)-1:0]                 slot,
  input  lrupr_pkg::lrupr_dec_t                         dec,
  output logic [MAX_FRAMES-1:0][lrupr_pkg::PAGE_W-1:0]  page_r,
  output logic [MAX_FRAMES-1:0]                         valid_r,
  output logic [MAX_FRAMES-1:0][$clog2(MAX_FRAMES)-1:0] rank_r,
  output logic [lrupr_pkg::FAULT_W-1:0]                 fault_count
);
  import lrupr_pkg::*;

  localparam int FIDX_W = $clog2(MAX_FRAMES);
  localparam int RANK_W = $clog2(MAX_FRAMES);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

  logic [MAX_FRAMES-1:0][PAGE_W-1:0] page_nxt;
  logic [MAX_FRAMES-1:0]             valid_nxt;
  logic [MAX_FRAMES-1:0][RANK_W-1:0] rank_nxt;
  logic [FAULT_W-1:0]                fault_r;
  logic [FAULT_W-1:0]                fault_nxt;
  logic [RANK_W:0]                   old_rank;

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    fault_nxt = fault_r;
    old_rank  = (dec.hit || dec.evicted) ? {1'b0, rank_r[slot]} : (RANK_W + 1)'(MAX_FRAMES);
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (FIDX_W'(i) != slot && valid_r[i] && {1'b0, rank_r[i]} < old_rank &&
          rank_r[i] < RANK_MAX) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end
    end
    rank_nxt[slot] = '0;
    if (!dec.hit) begin
      page_nxt[slot]  = page;
      valid_nxt[slot] = 1'b1;
      if (fault_r != '1) fault_nxt = fault_r + 1'b1;
    end
  end

  assign fault_count = fault_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
      fault_r <= '0;
    end else if (apply) begin
      if (last) begin
        valid_r <= '0;
        rank_r  <= '0;
        fault_r <= '0;
      end else begin
        valid_r <= valid_nxt;
        rank_r  <= rank_nxt;
        fault_r <= fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) page_r <= page_nxt;
  end

endmodule

### hw/rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement: one reference per cycle, bar stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one page reference per request.
//   out_valid/out_ready/out_data carry the result: hit, frame used, evicted
//   page and the running saturating fault count.
//   cfg_we/cfg_wdata set the number of active frames; write only when idle.
// Path: an accepted request passes the input register, then lookup and frame
//   update into the result register, which drives out_valid.
// Throughput: one request per cycle while out_ready is high; the lookup is
//   combinational, comparing all frames and picking the victim in parallel.
// Reset: all frames empty, fault count zero, three active frames.
// Stall: while out_ready is low the result holds, the input register holds
//   one more request, and in_ready drops once both are full.
// A request marked last_reference empties all frames after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lrupr_pkg::lrupr_req_t      in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lrupr_pkg::lrupr_rsp_t      out_data,
  input  logic                       cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata
);
  import lrupr_pkg::*;

  localparam int FIDX_W = $clog2(MAX_FRAMES);
  localparam int RANK_W = $clog2(MAX_FRAMES);
  localparam int N_W    = (CFG_W + 1 > $clog2(MAX_FRAMES + 1)) ? CFG_W + 1
                                                               : $clog2(MAX_FRAMES + 1);

  logic [CFG_W-1:0]                  frames_in_use_r;
  logic [N_W-1:0]                    cfg_ext;
  logic [N_W-1:0]                    n_active;
  logic [MAX_FRAMES-1:0]             active;

  logic                              s1_valid_r;
  lrupr_req_t                        s1_req_r;
  logic                              s1_adv;

  logic                              out_valid_r;
  lrupr_rsp_t                        out_data_r;
  lrupr_rsp_t                        rsp;

  logic [MAX_FRAMES-1:0][PAGE_W-1:0] page_r;
  logic [MAX_FRAMES-1:0]             valid_r;
  logic [MAX_FRAMES-1:0][RANK_W-1:0] rank_r;
  lrupr_dec_t                        dec;
  logic [FIDX_W-1:0]                 slot;
  logic [PAGE_W-1:0]                 ev_page;
  logic [FAULT_W-1:0]                fault_count;
  logic [FIDX_W+FRAME_IDX_W-1:0]     slot_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_RESET;
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  always_comb begin
    cfg_ext = N_W'(frames_in_use_r);
    if (cfg_ext == '0) begin
      n_active = N_W'(1);
    end else if (cfg_ext > N_W'(MAX_FRAMES)) begin
      n_active = N_W'(MAX_FRAMES);
    end else begin
      n_active = cfg_ext;
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = N_W'(i) < n_active;
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_req_r <= in_data;
  end

  lrupr_lookup #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_lookup (
    .page    (s1_req_r.page),
    .active  (active),
    .page_r  (page_r),
    .valid_r (valid_r),
    .rank_r  (rank_r),
    .dec     (dec),
    .slot    (slot),
    .ev_page (ev_page)
  );

  lrupr_frames #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_frames (
    .clk         (clk),
    .rst_n       (rst_n),
    .apply       (s1_adv),
    .last        (s1_req_r.last_reference),
    .page        (s1_req_r.page),
    .slot        (slot),
    .dec         (dec),
    .page_r      (page_r),
    .valid_r     (valid_r),
    .rank_r      (rank_r),
    .fault_count (fault_count)
  );

  assign slot_ext = (FIDX_W + FRAME_IDX_W)'(slot);

  always_comb begin
    rsp.hit           = dec.hit;
    rsp.frame_index   = slot_ext[FRAME_IDX_W-1:0];
    rsp.evicted_valid = dec.evicted;
    rsp.evicted_page  = ev_page;
    rsp.fault_count   = fault_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_data_r <= rsp;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!s1_valid_r || s1_adv))
    else $error("input register overwritten while holding a request");

  a_hit_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> (out_data.fault_count != '0))
    else $error("hit reported with zero faults in the string");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.evicted_valid) |-> !out_data.hit)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.evicted_valid) |-> (out_data.evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  a_result_slot_active: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> active[slot])
    else $error("result uses an inactive frame");

endmodule
